// ===== hdl/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared constants and types of the polynomial product engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

    localparam int DEF_MAX_TERMS   = 16;
    localparam int DEF_COEFF_WIDTH = 32;
    localparam int FRAC_BITS       = 16;
    localparam int DATA_W          = 32;
    localparam int DEG_W           = 5;
    localparam int OUT_TDATA_W     = 40;

    // Tag of one multiply-accumulate term as it moves through the MAC pipe.
    typedef struct packed {
        logic valid;   // term present in this stage
        logic first;   // first term of a product coefficient
        logic last;    // last term of a product coefficient
        logic fin;     // last term of the last coefficient
    } t_term_ctl;

endpackage

// ===== hdl/ppe_coeff_mem.sv =====
// ----------------------------------------------------------------------------
// ppe_coeff_mem
// Coefficient store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppe_coeff_mem
    import ppe_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_TERMS,
    parameter int WIDTH = DEF_COEFF_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                  i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ppe_seq.sv =====
// ----------------------------------------------------------------------------
// ppe_seq
// Term sequencer: walks k over the product degrees and i over the valid
// first-polynomial indexes, one term per cycle.
// ----------------------------------------------------------------------------
module ppe_seq
    import ppe_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [$clog2(MAX_TERMS+1)-1:0]         i_na,
    input  logic [$clog2(MAX_TERMS+1)-1:0]         i_nb,
    output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] o_a_addr,
    output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] o_b_addr,
    output t_term_ctl                              o_ctl
);

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int KW = $clog2(2 * MAX_TERMS);

    logic          r_active;
    logic [KW-1:0] r_k;
    logic [KW-1:0] r_i;
    logic [KW-1:0] r_na;
    logic [KW-1:0] r_nb;
    logic [KW-1:0] r_klast;

    logic [KW-1:0] w_j;
    logic [KW-1:0] w_ilo;
    logic [KW-1:0] w_ihi;
    logic [KW-1:0] w_kn;
    logic [KW-1:0] w_ilo_n;
    logic          w_last;
    logic          w_fin;

    always_comb begin
        w_j     = r_k - r_i;
        w_ilo   = (r_k >= r_nb) ? (r_k - r_nb + KW'(1)) : '0;
        w_ihi   = (r_k < r_na) ? r_k : (r_na - KW'(1));
        w_kn    = r_k + KW'(1);
        w_ilo_n = (w_kn >= r_nb) ? (w_kn - r_nb + KW'(1)) : '0;
        w_last  = (r_i == w_ihi);
        w_fin   = w_last && (r_k == r_klast);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (r_active && w_fin) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_na    <= KW'(i_na);
            r_nb    <= KW'(i_nb);
            r_klast <= KW'(i_na) + KW'(i_nb) - KW'(2);
            r_k     <= '0;
            r_i     <= '0;
        end else if (r_active) begin
            if (w_last) begin
                r_k <= w_kn;
                r_i <= w_ilo_n;
            end else begin
                r_i <= r_i + KW'(1);
            end
        end
    end

    assign o_a_addr    = r_i[IW-1:0];
    assign o_b_addr    = w_j[IW-1:0];
    assign o_ctl.valid = r_active;
    assign o_ctl.first = (r_i == w_ilo);
    assign o_ctl.last  = w_last;
    assign o_ctl.fin   = w_fin;

endmodule

// ===== hdl/ppe_mac.sv =====
// ----------------------------------------------------------------------------
// ppe_mac
// Shared multiply-accumulate unit: multiply, accumulate, round and saturate.
// ----------------------------------------------------------------------------
module ppe_mac
    import ppe_pkg::*;
#(
    parameter int MAX_TERMS   = DEF_MAX_TERMS,
    parameter int COEFF_WIDTH = DEF_COEFF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  t_term_ctl                     i_ctl,
    input  logic signed [COEFF_WIDTH-1:0] i_a,
    input  logic signed [COEFF_WIDTH-1:0] i_b,
    output logic                          o_res_valid,
    output logic                          o_res_done,
    output logic signed [COEFF_WIDTH-1:0] o_res,
    output logic                          o_sat
);

    localparam int PW = 2 * COEFF_WIDTH;
    localparam int AW = PW + $clog2(MAX_TERMS + 1) + 1;
    localparam logic signed [AW-1:0] HALF =
        {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [AW-1:0] HI_LIM =
        {{(AW-COEFF_WIDTH+1){1'b0}}, {(COEFF_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] LO_LIM = ~HI_LIM;

    t_term_ctl r_c1, r_c2, r_c3;
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc;
    logic signed [AW-1:0]          w_prod_ext;
    logic signed [AW-1:0]          w_round;
    logic signed [COEFF_WIDTH-1:0] w_clip;
    logic                          w_clip_hit;
    logic signed [COEFF_WIDTH-1:0] r_res;
    logic                          r_res_valid;
    logic                          r_res_done;
    logic                          r_sat;

    always_comb begin
        w_prod_ext = AW'(r_prod);
        w_round    = (r_acc + HALF) >>> FRAC_BITS;
        w_clip_hit = 1'b1;
        if (w_round > HI_LIM) begin
            w_clip = HI_LIM[COEFF_WIDTH-1:0];
        end else if (w_round < LO_LIM) begin
            w_clip = LO_LIM[COEFF_WIDTH-1:0];
        end else begin
            w_clip     = w_round[COEFF_WIDTH-1:0];
            w_clip_hit = 1'b0;
        end
    end

    // Tag pipeline follows the registered memory read, the product and the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1        <= '0;
            r_c2        <= '0;
            r_c3        <= '0;
            r_res_valid <= 1'b0;
            r_res_done  <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            r_c1        <= i_ctl;
            r_c2        <= r_c1;
            r_c3        <= r_c2;
            r_res_valid <= r_c3.valid && r_c3.last;
            r_res_done  <= r_c3.valid && r_c3.fin;
            if (i_start) begin
                r_sat <= 1'b0;
            end else if (r_c3.valid && r_c3.last && w_clip_hit) begin
                r_sat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_c2.valid) begin
            r_acc <= r_c2.first ? w_prod_ext : (r_acc + w_prod_ext);
        end
        if (r_c3.valid && r_c3.last) begin
            r_res <= w_clip;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_done  = r_res_done;
    assign o_res       = r_res;
    assign o_sat       = r_sat;

endmodule

// ===== hdl/polynomial_product_engine.sv =====
// ----------------------------------------------------------------------------
// polynomial_product_engine
// Flow: coefficient beats are taken only in the load state. A closing beat
//   starts the MAC terms, one MAC term per cycle through the shared pipeline,
//   and the result beats are then read from the result buffer in turn.
// Input stall: from a closing beat until the last result beat enters the output
//   register, also with an empty first list, and longer while a beat is held off.
// Reset: synchronous, active low; clears counts, flags and handshake state.
// ----------------------------------------------------------------------------
module polynomial_product_engine
    import ppe_pkg::*;
#(
    parameter int MAX_TERMS   = DEF_MAX_TERMS,
    parameter int COEFF_WIDTH = DEF_COEFF_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave side: coefficient loads.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] coeff_in
    input  logic                   s_axis_tuser,   // [0] func
    input  logic                   s_axis_tlast,   // last_in
    // Master side: product coefficients.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] coeff_out, [36:32] degree_out
    output logic                   m_axis_tuser,   // [0] overflow_flag
    output logic                   m_axis_tlast    // last_out
);

    localparam int IW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNTW      = $clog2(MAX_TERMS + 1);
    localparam int KW        = $clog2(2 * MAX_TERMS);
    localparam int RES_DEPTH = 2 * MAX_TERMS - 1;
    localparam int RW        = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

    localparam logic FUNC_FIRST  = 1'b0;
    localparam logic FUNC_SECOND = 1'b1;

    // Sequencer states
    localparam logic [1:0] ST_LOAD  = 2'd0;  // take coefficient beats
    localparam logic [1:0] ST_CALC  = 2'd1;  // run the MAC, fill result buffer
    localparam logic [1:0] ST_EMIT  = 2'd2;  // read one result
    localparam logic [1:0] ST_EWAIT = 2'd3;  // move it to the output register

    logic [1:0]            r_state;

    // Load-side bookkeeping
    logic [CNTW-1:0]       r_a_cnt;
    logic                  r_a_open;
    logic [CNTW-1:0]       r_b_cnt;
    logic                  r_dropped;

    // Product bookkeeping
    logic [KW-1:0]         r_n;       // number of result beats
    logic [KW-1:0]         r_wk;      // result buffer write index
    logic [KW-1:0]         r_ek;      // emit index
    logic                  r_empty;   // empty first polynomial
    logic                  r_ovf_drop;

    // Output register
    logic                  r_m_valid;
    logic [DATA_W-1:0]     r_m_coeff;
    logic [DEG_W-1:0]      r_m_deg;
    logic                  r_m_last;
    logic                  r_m_ovf;

    // Result buffer
    logic signed [COEFF_WIDTH-1:0] r_res_mem [RES_DEPTH];
    logic signed [COEFF_WIDTH-1:0] r_rd_data;

    logic                  w_in_acc;
    logic [COEFF_WIDTH-1:0] w_coeff;
    logic [CNTW-1:0]       w_a_base;
    logic                  w_a_we;
    logic                  w_b_full;
    logic                  w_b_we;
    logic                  w_trig;
    logic [CNTW-1:0]       w_nb_new;
    logic                  w_start;
    logic                  w_out_load;
    logic                  w_emit_last;
    logic [KW+DEG_W-1:0]   w_ek_ext;

    logic [IW-1:0]         w_a_raddr;
    logic [IW-1:0]         w_b_raddr;
    logic [COEFF_WIDTH-1:0] w_a_rdata;
    logic [COEFF_WIDTH-1:0] w_b_rdata;
    t_term_ctl             w_ctl;
    logic                  w_res_valid;
    logic                  w_res_done;
    logic signed [COEFF_WIDTH-1:0] w_res;
    logic                  w_sat;

    // ------------------------------------------------------------------
    // Input side. A first-list beat with no list open restarts the list
    // at entry zero; beats past MAX_TERMS are dropped but still count
    // their last mark. The closing beat of the second list starts a product.
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_LOAD);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_coeff       = s_axis_tdata[COEFF_WIDTH-1:0];

    always_comb begin
        w_a_base = r_a_open ? r_a_cnt : '0;
        w_a_we   = w_in_acc && (s_axis_tuser == FUNC_FIRST) &&
                   (w_a_base != CNTW'(MAX_TERMS));
        w_b_full = (r_b_cnt == CNTW'(MAX_TERMS));
        w_b_we   = w_in_acc && (s_axis_tuser == FUNC_SECOND) && !w_b_full;
        w_trig   = w_in_acc && (s_axis_tuser == FUNC_SECOND) && s_axis_tlast;
        w_nb_new = w_b_full ? r_b_cnt : (r_b_cnt + CNTW'(1));
        w_start  = w_trig && (r_a_cnt != '0);
    end

    ppe_coeff_mem #(
        .DEPTH (MAX_TERMS),
        .WIDTH (COEFF_WIDTH)
    ) u_first_mem (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_base[IW-1:0]),
        .i_wdata (w_coeff),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    ppe_coeff_mem #(
        .DEPTH (MAX_TERMS),
        .WIDTH (COEFF_WIDTH)
    ) u_second_mem (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (r_b_cnt[IW-1:0]),
        .i_wdata (w_coeff),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // ------------------------------------------------------------------
    // Term sequencer and the shared MAC unit.
    // ------------------------------------------------------------------
    ppe_seq #(
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_na     (r_a_cnt),
        .i_nb     (w_nb_new),
        .o_a_addr (w_a_raddr),
        .o_b_addr (w_b_raddr),
        .o_ctl    (w_ctl)
    );

    ppe_mac #(
        .MAX_TERMS   (MAX_TERMS),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_ctl       (w_ctl),
        .i_a         (w_a_rdata),
        .i_b         (w_b_rdata),
        .o_res_valid (w_res_valid),
        .o_res_done  (w_res_done),
        .o_res       (w_res),
        .o_sat       (w_sat)
    );

    // ------------------------------------------------------------------
    // Control state: list counts, drop flag and the sequencer.
    // ------------------------------------------------------------------
    assign w_out_load  = (r_state == ST_EWAIT) && (!r_m_valid || m_axis_tready);
    assign w_emit_last = (r_ek == (r_n - KW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_a_cnt   <= '0;
            r_a_open  <= 1'b0;
            r_b_cnt   <= '0;
            r_dropped <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_in_acc && (s_axis_tuser == FUNC_FIRST)) begin
                r_a_open <= !s_axis_tlast;
                if (w_a_base == CNTW'(MAX_TERMS)) begin
                    r_a_cnt   <= w_a_base;
                    r_dropped <= 1'b1;
                end else begin
                    r_a_cnt <= w_a_base + CNTW'(1);
                end
            end
            if (w_in_acc && (s_axis_tuser == FUNC_SECOND)) begin
                if (s_axis_tlast) begin
                    // Close the product: restart the second list, clear drops.
                    r_b_cnt   <= '0;
                    r_dropped <= 1'b0;
                end else if (w_b_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_b_cnt <= w_nb_new;
                end
            end

            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_LOAD: begin
                    if (w_trig) begin
                        r_state <= w_start ? ST_CALC : ST_EMIT;
                    end
                end
                ST_CALC: begin
                    if (w_res_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_state <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (w_out_load) begin
                        r_state <= w_emit_last ? ST_LOAD : ST_EMIT;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Product bookkeeping and the result buffer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_trig) begin
            r_empty    <= !w_start;
            r_ovf_drop <= r_dropped || w_b_full;
            r_n        <= w_start ? (KW'(r_a_cnt) + KW'(w_nb_new) - KW'(1)) : KW'(1);
            r_wk       <= '0;
            r_ek       <= '0;
        end else begin
            if (w_res_valid) begin
                r_wk <= r_wk + KW'(1);
            end
            if (w_out_load) begin
                r_ek <= r_ek + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_res_mem[r_wk[RW-1:0]] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT) begin
            r_rd_data <= r_res_mem[r_ek[RW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Output register. Hold a beat until taken; degree wraps at five bits.
    // ------------------------------------------------------------------
    assign w_ek_ext = {{DEG_W{1'b0}}, r_ek};

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_coeff <= r_empty ? '0 : DATA_W'(r_rd_data);
            r_m_deg   <= w_ek_ext[DEG_W-1:0];
            r_m_last  <= w_emit_last;
            r_m_ovf   <= r_ovf_drop || (w_sat && !r_empty);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-DEG_W){1'b0}}, r_m_deg, r_m_coeff};
    assign m_axis_tuser  = r_m_ovf;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTHESIS
    // No MAC result may arrive outside a running product.
    a_res_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_state == ST_CALC))
        else $error("MAC result outside of product computation");

    // The result buffer never receives more coefficients than the product has.
    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_wk < r_n))
        else $error("result buffer overrun");

    // An empty first polynomial yields a single result beat.
    a_empty_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_empty) |-> (r_n == KW'(1)))
        else $error("empty product with more than one result");

    // Once all results are written, the emit phase starts next.
    a_done_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_done && (r_state == ST_CALC)) |=> (r_state == ST_EMIT))
        else $error("product done without entering emit");
`endif

endmodule
